### rtl/core/swdsf_pkg.sv
package swdsf_pkg;

    // Fixed field widths
    localparam int DATA_W     = 32;
    localparam int KB_SHIFT   = 10;
    localparam int WSIZE_W    = 8;
    localparam int LIMIT_W    = 7;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int FILL_W     = 8;
    localparam int TOTAL_W    = 32;

    localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST = 8'd100;
    localparam logic [LIMIT_W-1:0] DUP_LIMIT_RST   = 7'd30;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX       = {TOTAL_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_SIZE = 1'b0,
        CFG_DUP_LIMIT   = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        ACT_CHECK = 1'b0,
        ACT_PUSH  = 1'b1
    } action_t;

endpackage

### rtl/core/sliding_window_duplicate_size_filter.sv
// Sliding-window duplicate size filter. Keeps the last window_size item sizes
// (in kilobytes, byte size with the low ten bits dropped) in a circular buffer
// held in one synchronous RAM. A transfer is taken when start is high and busy
// is low. A push (action = 1) appends the size, dropping the oldest entry when
// the window is full. A check (action = 0) reads every stored entry, one RAM
// read per cycle, counts the entries equal to the queried size and flags
// discard when the count exceeds dup_limit; it skips the reads and never flags
// when window_size is not above dup_limit or the window is empty. Every
// transfer yields exactly one result, shown for one cycle with done high; the
// receiver cannot stall it, so sample discard, discards_so_far and fill_level
// in that cycle. A new item may be started in the same cycle that done is
// high. Write window_size and dup_limit through cfg_we / cfg_index / cfg_data
// only while the block is idle.
module sliding_window_duplicate_size_filter #(
    parameter int WINDOW_DEPTH = 128,
    parameter int SIZE_BITS    = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 action,
    input  logic [swdsf_pkg::DATA_W-1:0]         data_size,
    output logic                                 done,
    output logic                                 discard,
    output logic [swdsf_pkg::TOTAL_W-1:0]        discards_so_far,
    output logic [swdsf_pkg::FILL_W-1:0]         fill_level,
    input  logic                                 cfg_we,
    input  logic [swdsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swdsf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import swdsf_pkg::*;

    // Bits of data_size that survive the size mask, and the stored width
    localparam int MASK_W = (SIZE_BITS < DATA_W) ? SIZE_BITS : DATA_W;
    localparam int KB_W   = MASK_W - KB_SHIFT;
    localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = IDX_W + 1;
    localparam int CMP_W  = (CNT_W > WSIZE_W) ? CNT_W : WSIZE_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    // Wrap a slot sum (always below twice the depth) back into the ring
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        r = s;
        if (s >= SUM_W'(WINDOW_DEPTH))
        begin
            r = s - SUM_W'(WINDOW_DEPTH);
        end
        return r[IDX_W-1:0];
    endfunction

    // Window RAM
    logic [KB_W-1:0] size_window_mem [WINDOW_DEPTH];
    logic [KB_W-1:0] rd_data_reg;

    state_t              state_reg,     state_next;
    logic [KB_W-1:0]     kb_reg,        kb_next;
    logic [IDX_W-1:0]    oldest_reg,    oldest_next;
    logic [CNT_W-1:0]    count_reg,     count_next;
    logic [TOTAL_W-1:0]  total_reg,     total_next;
    logic [WSIZE_W-1:0]  wsize_reg,     wsize_next;
    logic [LIMIT_W-1:0]  limit_reg,     limit_next;
    logic [IDX_W-1:0]    rd_ptr_reg,    rd_ptr_next;
    logic [CNT_W-1:0]    left_reg,      left_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [CNT_W-1:0]    matches_reg,   matches_next;
    logic                done_reg,      done_next;
    logic                discard_reg,   discard_next;

    logic                accept;
    logic                rd_en;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [CMP_W-1:0]    capacity;
    logic                window_full;
    logic                flag;
    logic                scan_enable;

    assign accept = start && (state_reg == ST_IDLE);

    // Capacity: zero acts as one, anything above the RAM depth as the depth
    always_comb
    begin
        capacity = CMP_W'(wsize_reg);
        if (wsize_reg == '0)
        begin
            capacity = CMP_W'(1);
        end
        else if (CMP_W'(wsize_reg) > CMP_W'(WINDOW_DEPTH))
        begin
            capacity = CMP_W'(WINDOW_DEPTH);
        end
    end

    assign window_full = CMP_W'(count_reg) >= capacity;

    // Next free slot; after dropping the oldest it lands on the same place
    assign wr_addr = wrap_idx(SUM_W'(oldest_reg) + SUM_W'(count_reg));
    assign wr_en   = (state_reg == ST_PUSH);
    assign rd_en   = (state_reg == ST_SCAN) && (left_reg != '0);

    // Raw register values decide whether a check may ever discard
    assign scan_enable = (wsize_reg > {1'b0, limit_reg}) && (count_reg != '0);
    assign flag        = CMP_W'(matches_reg) > CMP_W'(limit_reg);

    always_comb
    begin
        state_next     = state_reg;
        kb_next        = kb_reg;
        oldest_next    = oldest_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        wsize_next     = wsize_reg;
        limit_next     = limit_reg;
        rd_ptr_next    = rd_ptr_reg;
        left_next      = left_reg;
        cmp_valid_next = rd_en;
        matches_next   = matches_reg;
        done_next      = 1'b0;
        discard_next   = discard_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW_SIZE: wsize_next = cfg_data[WSIZE_W-1:0];
                CFG_DUP_LIMIT:   limit_next = cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kb_next      = data_size[MASK_W-1:KB_SHIFT];
                    rd_ptr_next  = oldest_reg;
                    left_next    = count_reg;
                    matches_next = '0;
                    if (action == ACT_PUSH)
                    begin
                        state_next = ST_PUSH;
                    end
                    else if (scan_enable)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_PUSH:
            begin
                // Full window: drop the oldest, fill level holds
                if (window_full)
                begin
                    oldest_next = wrap_idx(SUM_W'(oldest_reg) + SUM_W'(1));
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                done_next    = 1'b1;
                discard_next = 1'b0;
                state_next   = ST_IDLE;
            end

            ST_SCAN:
            begin
                if (rd_en)
                begin
                    rd_ptr_next = wrap_idx(SUM_W'(rd_ptr_reg) + SUM_W'(1));
                    left_next   = left_reg - CNT_W'(1);
                end
                if (cmp_valid_reg && (rd_data_reg == kb_reg))
                begin
                    matches_next = matches_reg + CNT_W'(1);
                end
                // Last read was issued a cycle ago; its compare lands now
                if (left_reg == '0)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if (flag && (total_reg != TOTAL_MAX))
                begin
                    total_next = total_reg + TOTAL_W'(1);
                end
                done_next    = 1'b1;
                discard_next = flag;
                state_next   = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            oldest_reg    <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            wsize_reg     <= WINDOW_SIZE_RST;
            limit_reg     <= DUP_LIMIT_RST;
            rd_ptr_reg    <= '0;
            left_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            matches_reg   <= '0;
            done_reg      <= 1'b0;
            discard_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            wsize_reg     <= wsize_next;
            limit_reg     <= limit_next;
            rd_ptr_reg    <= rd_ptr_next;
            left_reg      <= left_next;
            cmp_valid_reg <= cmp_valid_next;
            matches_reg   <= matches_next;
            done_reg      <= done_next;
            discard_reg   <= discard_next;
        end
    end

    // Payload latch, no reset needed
    always_ff @(posedge clk)
    begin
        kb_reg <= kb_next;
    end

    // Window RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            size_window_mem[wr_addr] <= kb_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= size_window_mem[rd_ptr_reg];
        end
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign discard         = discard_reg;
    assign discards_so_far = total_reg;
    assign fill_level      = FILL_W'(count_reg);

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import swdsf_pkg::*;

    localparam int DEPTH         = 128;
    localparam int KB_W          = DATA_W - KB_SHIFT;
    localparam int CYCLE_LIMIT   = 1_200_000;
    localparam int SETTLE_CYCLES = 140;

    typedef enum logic [1:0] {
        OP_ITEM,
        OP_CFG,
        OP_DRAIN
    } op_kind_t;

    typedef struct packed {
        op_kind_t              kind;
        action_t               act;
        logic [DATA_W-1:0]     bytes;
        cfg_idx_t              reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [6:0]            gap_pct;
    } op_t;

    typedef struct packed {
        logic               discard;
        logic [TOTAL_W-1:0] total;
        logic [FILL_W-1:0]  fill;
    } verdict_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  action = 1'b0;
    logic [DATA_W-1:0]     data_size = '0;
    logic                  done;
    logic                  discard;
    logic [TOTAL_W-1:0]    discards_so_far;
    logic [FILL_W-1:0]     fill_level;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    sliding_window_duplicate_size_filter dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .data_size       (data_size),
        .done            (done),
        .discard         (discard),
        .discards_so_far (discards_so_far),
        .fill_level      (fill_level),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Operations waiting for the driver, and verdicts waiting for a done strobe
    op_t      pending[$];
    verdict_t verdict_q[$];

    // Transfer counters: n_sent belongs to the driver, n_recv to the monitor
    int n_sent    = 0;
    int n_recv    = 0;
    int errors    = 0;
    int cycles    = 0;
    int idle_left = 0;

    // Coverage tallies for the closing summary
    int n_pushes    = 0;
    int n_checks    = 0;
    int n_flags     = 0;
    int n_cfg       = 0;
    int peak_fill   = 0;

    // Predictor state: a circular window of kilobyte sizes plus the registers
    logic [KB_W-1:0]    kb_window [0:DEPTH-1];
    logic [6:0]         win_head      = '0;
    logic [FILL_W-1:0]  win_fill      = '0;
    logic [TOTAL_W-1:0] discard_total = '0;
    logic [WSIZE_W-1:0] win_size_reg  = WINDOW_SIZE_RST;
    logic [LIMIT_W-1:0] dup_limit_reg = DUP_LIMIT_RST;

    // Advance the window by one transfer and return the verdict it must produce.
    function automatic verdict_t filter_item(action_t act, logic [DATA_W-1:0] bytes);
        logic [KB_W-1:0]   kb;
        logic [FILL_W-1:0] cap;
        logic [6:0]        slot;
        int                hit_count;
        verdict_t          v;
        kb = bytes[DATA_W-1:KB_SHIFT];
        // A zero size still holds one entry; anything past the depth clamps to it
        if (win_size_reg == 0)
            cap = FILL_W'(1);
        else if (win_size_reg > DEPTH)
            cap = FILL_W'(DEPTH);
        else
            cap = win_size_reg;
        v.discard = 1'b0;
        if (act == ACT_PUSH) begin
            // Drop exactly one oldest entry when at or over capacity, so a
            // shrunk window keeps its fill instead of falling to the new size
            if (win_fill >= cap && win_fill != 0) begin
                win_head = win_head + 7'd1;
                win_fill = win_fill - 1'b1;
            end
            slot = win_head + win_fill[6:0];
            kb_window[slot] = kb;
            win_fill = win_fill + 1'b1;
            n_pushes++;
        end else begin
            n_checks++;
            // A window no larger than the limit can never flag
            if (win_size_reg > dup_limit_reg) begin
                hit_count = 0;
                for (int i = 0; i < win_fill; i++) begin
                    slot = win_head + 7'(i);
                    if (kb_window[slot] == kb)
                        hit_count++;
                end
                if (hit_count > dup_limit_reg) begin
                    v.discard = 1'b1;
                    n_flags++;
                    if (discard_total != TOTAL_MAX)
                        discard_total = discard_total + 1'b1;
                end
            end
        end
        if (win_fill > peak_fill)
            peak_fill = win_fill;
        v.total = discard_total;
        v.fill  = win_fill;
        return v;
    endfunction

    initial begin
        forever #2 clk = ~clk;
    end

    // Hold reset at the start, then release it for good
    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Driver: one start or one config write per edge, pulled from pending, unless a start waits on busy.
    // Config writes and drain markers wait until every verdict is back.
    always @(posedge clk or negedge rst_n) begin
        op_t  head;
        logic next_start;
        logic next_we;
        if (!rst_n) begin
            start  <= 1'b0;
            cfg_we <= 1'b0;
        end else begin
            next_start = start;
            next_we    = 1'b0;
            // A transfer completes on this edge: predict its verdict now
            if (start && !busy) begin
                verdict_q.insert(verdict_q.size(), filter_item(action_t'(action), data_size));
                n_sent++;
                next_start = 1'b0;
            end
            if (!next_start) begin
                if (idle_left > 0) begin
                    idle_left--;
                end else if (pending.size() != 0) begin
                    head = pending[0];
                    case (head.kind)
                        OP_ITEM: begin
                            // Sit out an idle burst of random length, or present the item
                            if (head.gap_pct != 0 && $urandom_range(0, 99) < head.gap_pct) begin
                                idle_left = $urandom_range(0, 13);
                            end else begin
                                action     <= head.act;
                                data_size  <= head.bytes;
                                next_start = 1'b1;
                                pending.delete(0);
                            end
                        end
                        OP_CFG: begin
                            if (n_recv >= n_sent) begin
                                cfg_index <= head.reg_idx;
                                cfg_data  <= head.reg_val;
                                next_we   = 1'b1;
                                if (head.reg_idx == CFG_WINDOW_SIZE)
                                    win_size_reg = head.reg_val;
                                else
                                    dup_limit_reg = head.reg_val[LIMIT_W-1:0];
                                n_cfg++;
                                pending.delete(0);
                            end
                        end
                        default: begin
                            if (n_recv >= n_sent)
                                pending.delete(0);
                        end
                    endcase
                end
            end
            start  <= next_start;
            cfg_we <= next_we;
        end
    end

    // Monitor: every done strobe is a result transfer; match it to the
    // oldest predicted verdict field by field.
    always @(posedge clk or negedge rst_n) begin
        verdict_t want;
        if (!rst_n) begin
            n_recv <= 0;
        end else if (done) begin
            n_recv <= n_recv + 1;
            if (verdict_q.size() == 0) begin
                $error("result transfer with no verdict outstanding");
                errors++;
            end else begin
                want = verdict_q[0];
                verdict_q.delete(0);
                if (discard !== want.discard) begin
                    $error("discard: expected %0d, got %0d", want.discard, discard);
                    errors++;
                end
                if (discards_so_far !== want.total) begin
                    $error("discards_so_far: expected %0d, got %0d",
                           want.total, discards_so_far);
                    errors++;
                end
                if (fill_level !== want.fill) begin
                    $error("fill_level: expected %0d, got %0d", want.fill, fill_level);
                    errors++;
                end
            end
        end
    end

    task automatic add_item(action_t act, logic [DATA_W-1:0] bytes, int gap);
        op_t op;
        op = '0;
        op.kind    = OP_ITEM;
        op.act     = act;
        op.bytes   = bytes;
        op.gap_pct = 7'(gap);
        pending.insert(pending.size(), op);
    endtask

    task automatic add_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        op_t op;
        op = '0;
        op.kind    = OP_CFG;
        op.reg_idx = idx;
        op.reg_val = val;
        pending.insert(pending.size(), op);
    endtask

    task automatic add_drain();
        op_t op;
        op = '0;
        op.kind = OP_DRAIN;
        pending.insert(pending.size(), op);
    endtask

    initial begin
        logic [KB_W-1:0]   pool [0:3];
        logic [DATA_W-1:0] bytes;
        action_t           act;
        int                phase;
        int                ws;
        int                cap;
        int                dl;
        int                pool_n;
        int                gap;
        int                phase_len;
        int                queued;

        // Directed part.
        // Check on an empty window with reset settings.
        add_item(ACT_CHECK, 32'h0000_0000, 25);
        // Zero window size holds a single entry; low ten bits never matter.
        add_cfg(CFG_WINDOW_SIZE, 8'd0);
        add_cfg(CFG_DUP_LIMIT, 8'd0);
        add_item(ACT_PUSH, 32'h0000_0400, 25);
        add_item(ACT_PUSH, 32'h0000_07FF, 25);
        add_item(ACT_PUSH, 32'hFFFF_FFFF, 25);
        add_item(ACT_CHECK, 32'hFFFF_FC00, 25);
        // Window of one above a zero limit: a single match flags.
        add_cfg(CFG_WINDOW_SIZE, 8'd1);
        add_item(ACT_CHECK, 32'hFFFF_FFFF, 25);
        add_item(ACT_CHECK, 32'h0000_0000, 25);
        // Grow to four and pile up one size.
        add_cfg(CFG_WINDOW_SIZE, 8'd4);
        add_item(ACT_PUSH, 32'h1234_5400, 25);
        add_item(ACT_PUSH, 32'h1234_57FF, 25);
        add_item(ACT_PUSH, 32'h1234_5678, 25);
        add_item(ACT_CHECK, 32'h1234_5400, 25);
        // Shrink below the fill with the limit at the window size: the fill
        // holds and matches beyond the limit still do not flag.
        add_cfg(CFG_WINDOW_SIZE, 8'd2);
        add_cfg(CFG_DUP_LIMIT, 8'd2);
        add_item(ACT_PUSH, 32'h1234_5678, 25);
        add_item(ACT_CHECK, 32'h1234_5678, 25);
        // Top bit of the limit write is dropped, leaving a limit of one.
        add_cfg(CFG_DUP_LIMIT, 8'h81);
        add_item(ACT_CHECK, 32'h1234_5678, 25);
        add_item(ACT_PUSH, 32'h0000_0000, 25);
        // Oversized window and the largest limit.
        add_cfg(CFG_WINDOW_SIZE, 8'd255);
        add_cfg(CFG_DUP_LIMIT, 8'h7F);
        add_item(ACT_PUSH, 32'h8000_0000, 25);
        add_item(ACT_CHECK, 32'h8000_0000, 25);
        add_item(ACT_PUSH, 32'h7FFF_FFFF, 25);
        // Hold off until the block has answered everything.
        add_drain();

        // Random phases: a fresh setting, a small pool of sizes so that
        // checks find real duplicates, and some raw noise.
        queued = 0;
        phase  = 0;
        while (queued < 1600) begin
            // Small windows first, since the fill never falls again
            case (phase)
                0: ws = 4;
                1: ws = 7;
                2: ws = 20;
                3: ws = 60;
                default: begin
                    case ($urandom_range(0, 9))
                        0: ws = 0;
                        1: ws = 1;
                        2: ws = 128;
                        3: ws = 255;
                        4: ws = $urandom_range(129, 254);
                        default: ws = $urandom_range(2, 127);
                    endcase
                end
            endcase
            cap    = (ws == 0) ? 1 : (ws > DEPTH) ? DEPTH : ws;
            pool_n = $urandom_range(1, 4);
            if ($urandom_range(0, 3) == 0)
                dl = $urandom_range(0, 127);
            else
                dl = $urandom_range(0, cap / pool_n);
            for (int p = 0; p < 4; p++)
                pool[p] = KB_W'($urandom);
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = 5;
                2: gap = 20;
                default: gap = 50;
            endcase
            add_cfg(CFG_WINDOW_SIZE, 8'(ws));
            add_cfg(CFG_DUP_LIMIT, {1'($urandom_range(0, 1)), 7'(dl)});
            phase_len = $urandom_range(30, 140);
            for (int k = 0; k < phase_len; k++) begin
                if (k == phase_len / 2 && $urandom_range(0, 1) == 1)
                    add_drain();
                if ($urandom_range(0, 99) < 8)
                    bytes = $urandom;
                else
                    bytes = {pool[$urandom_range(0, pool_n - 1)], 10'($urandom)};
                act = ($urandom_range(0, 99) < 55) ? ACT_PUSH : ACT_CHECK;
                add_item(act, bytes, gap);
            end
            queued += phase_len;
            phase++;
        end

        // Closing stretch at full depth and the largest limit, back to back:
        // a window packed with one size must exceed the limit.
        add_cfg(CFG_WINDOW_SIZE, 8'd128);
        add_cfg(CFG_DUP_LIMIT, 8'h7F);
        pool[0] = KB_W'($urandom);
        for (int k = 0; k < 220; k++) begin
            if ($urandom_range(0, 99) < 5)
                bytes = $urandom;
            else
                bytes = {pool[0], 10'($urandom)};
            act = ($urandom_range(0, 99) < 60) ? ACT_PUSH : ACT_CHECK;
            add_item(act, bytes, 0);
        end

        // Wait for every transfer and verdict, then let the block settle
        @(posedge rst_n);
        while (pending.size() != 0 || start || n_recv < n_sent)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (verdict_q.size() != 0) begin
            $error("%0d verdicts never arrived", verdict_q.size());
            errors++;
        end

        $display("Checked %0d pushes and %0d lookups, %0d flagged as duplicates; fill peaked at %0d.",
                 n_pushes, n_checks, n_flags, peak_fill);
        $display("Register writes: %0d, window sizes 0 to 255, limits 0 to 127.", n_cfg);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
